FILE: rtl/bot_pkg.sv
// ---------------------------------------------------------------------------
// bot_pkg: shared types and constants of the box overlap table
// table geometry, command codes, query and entry layouts, bound helpers
// ---------------------------------------------------------------------------
package bot_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // fixed field widths
    localparam int COORD_W  = 16;
    localparam int COUNT_W  = 9;
    localparam int BOUND_W  = COORD_W + 3;   // 2*centre +/- extent, Q.5
    localparam int NEAR_W   = COORD_W + 2;   // centre +/- pitch, Q.4

    // configuration port
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam logic REG_PITCH = 1'b0;        // word index of cell_pitch
    localparam logic [COORD_W-1:0] PITCH_RESET = 16'd16;

    typedef enum logic [1:0] {
        CMD_PLACE  = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef logic signed [BOUND_W-1:0] bound_t;
    typedef logic signed [NEAR_W-1:0]  near_t;

    // one stored box, x in the low lane
    typedef struct packed {
        logic [2:0][COORD_W-1:0] ext;
        logic [2:0][COORD_W-1:0] ctr;
    } entry_t;

    // precomputed bounds of the incoming box or point
    typedef struct packed {
        logic [2:0][BOUND_W-1:0] lo;
        logic [2:0][BOUND_W-1:0] hi;
        logic [2:0][NEAR_W-1:0]  near_lo;
        logic [2:0][NEAR_W-1:0]  near_hi;
    } qry_t;

    typedef struct packed {
        logic hit;    // box overlaps this entry
        logic near;   // entry centre within one pitch of the point
    } slot_res_t;

    function automatic bound_t bound_lo(logic [COORD_W-1:0] c, logic [COORD_W-1:0] s);
        bound_t c2;
        bound_t se;
        c2 = {{2{c[COORD_W-1]}}, c, 1'b0};
        se = {3'b000, s};
        return c2 - se;
    endfunction

    function automatic bound_t bound_hi(logic [COORD_W-1:0] c, logic [COORD_W-1:0] s);
        bound_t c2;
        bound_t se;
        c2 = {{2{c[COORD_W-1]}}, c, 1'b0};
        se = {3'b000, s};
        return c2 + se;
    endfunction

endpackage

FILE: rtl/bot_slot_eval.sv
// ---------------------------------------------------------------------------
// bot_slot_eval: compare one stored box against the current command
// open-interval overlap on three axes and the removal proximity test
// ---------------------------------------------------------------------------
module bot_slot_eval
    import bot_pkg::*;
(
    input  qry_t      qry,
    input  entry_t    ent,
    output slot_res_t res
);

    always_comb
    begin
        logic   all_ovl;
        logic   all_near;
        bound_t lo_b;
        bound_t hi_b;
        bound_t lo_a;
        bound_t hi_a;
        near_t  cb;
        all_ovl  = 1'b1;
        all_near = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            lo_b = bound_lo(ent.ctr[a], ent.ext[a]);
            hi_b = bound_hi(ent.ctr[a], ent.ext[a]);
            lo_a = $signed(qry.lo[a]);
            hi_a = $signed(qry.hi[a]);
            // max(lo) < min(hi) written as four compares
            if (!((lo_a < hi_a) && (lo_b < hi_b) && (lo_a < hi_b) && (lo_b < hi_a)))
                all_ovl = 1'b0;
            cb = {{2{ent.ctr[a][COORD_W-1]}}, ent.ctr[a]};
            if (!((cb > $signed(qry.near_lo[a])) && (cb < $signed(qry.near_hi[a]))))
                all_near = 1'b0;
        end
        res.hit  = all_ovl;
        res.near = all_near;
    end

endmodule

FILE: rtl/box_overlap_table_unit.sv
// ---------------------------------------------------------------------------
// box_overlap_table_unit: table of 3-D axis-aligned boxes
// place, remove-near-point and overlap query over a 256-slot box table
// ---------------------------------------------------------------------------
// Every command takes one input transfer and returns exactly one result
// transfer. A command sweeps the whole entry memory once through its single
// read port: it reads every slot in turn, evaluates the last read data,
// closes the sweep and then writes its result in the commit state. The input
// side stalls while a command is in work and takes the next command once the
// block has returned to idle after commit, so it cannot take a new command
// before the last one has committed. A finished result waits in the output
// register and does not hold up the next command; a second result that finds
// the output register still stalled waits in commit, and the input stays
// stalled until it can load. Boxes live in a synchronous entry memory (centre
// and extent, 96 bits a slot); the slot valid bits are flip-flops cleared at
// reset, so no clearing pass is needed. A placed box goes into the lowest
// free slot found during the sweep. cell_pitch sits at byte address 0 of the
// configuration port; the user must write it only while the block is idle;
// the block itself does not enforce this.
// ---------------------------------------------------------------------------
module box_overlap_table_unit
    import bot_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,

    // command channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                command,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [COORD_W-1:0] pos_z,
    input  logic [COORD_W-1:0]        size_x,
    input  logic [COORD_W-1:0]        size_y,
    input  logic [COORD_W-1:0]        size_z,
    input  logic                      use_custom_size,

    // result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      overlap_found,
    output logic                      placed,
    output logic                      out_of_range,
    output logic                      table_full,
    output logic [COUNT_W-1:0]        removed_count,
    output logic [COUNT_W-1:0]        entries_in_use
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t                 state_reg;
    logic [COORD_W-1:0]     pitch_reg;
    logic [CNT_W-1:0]       idx_reg;        // next slot to read
    logic                   eval_v_reg;     // read data of pend_idx_reg is valid
    logic [IDX_W-1:0]       pend_idx_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       rm_cnt_reg;
    logic                   hit_reg;
    logic                   free_found_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic                   out_valid_reg;

    // command payload
    cmd_t                   cmd_reg;
    logic                   oor_reg;
    qry_t                   qry_reg;
    entry_t                 new_ent_reg;

    // result payload
    logic                   overlap_reg;
    logic                   placed_reg;
    logic                   oor_out_reg;
    logic                   full_reg;
    logic [COUNT_W-1:0]     removed_reg;
    logic [COUNT_W-1:0]     in_use_reg;

    // entry memory
    entry_t                 ent_mem [TABLE_DEPTH];
    entry_t                 rdata_reg;

    logic                   in_fire;
    logic                   cfg_wr;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   slot_v;
    slot_res_t              slot_res;
    logic                   commit_fire;
    logic                   is_pq;
    logic                   place_ok;
    logic                   do_place;
    logic [2:0][COORD_W-1:0] in_pos;
    logic [2:0][COORD_W-1:0] in_size;
    qry_t                   qry_in;
    logic                   oor_in;

    // ---- configuration port ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PITCH);
    assign prdata = (paddr[2] == REG_PITCH) ? {{(DATA_W-COORD_W){1'b0}}, pitch_reg} : '0;

    // ---- handshakes ----
    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // ---- command setup: interval ends and removal window per axis ----
    assign in_pos = {pos_z, pos_y, pos_x};
    assign in_size = use_custom_size ? {size_z, size_y, size_x}
                                     : {pitch_reg, pitch_reg, pitch_reg};

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            qry_in.lo[a]      = bound_lo(in_pos[a], in_size[a]);
            qry_in.hi[a]      = bound_hi(in_pos[a], in_size[a]);
            qry_in.near_lo[a] = near_t'($signed(in_pos[a])) - near_t'({2'b00, pitch_reg});
            qry_in.near_hi[a] = near_t'($signed(in_pos[a])) + near_t'({2'b00, pitch_reg});
        end
    end

    // at or below -1.0 is at or below -16 in Q11.4
    assign oor_in = (pos_x <= -16) || (pos_y <= -16) || (pos_z <= -16);

    // ---- sweep ----
    assign rd_en   = (state_reg == S_SCAN) && (idx_reg < CNT_W'(TABLE_DEPTH));
    assign rd_addr = idx_reg[IDX_W-1:0];
    assign slot_v  = valid_reg[pend_idx_reg];

    bot_slot_eval u_slot_eval
    (
        .qry (qry_reg),
        .ent (rdata_reg),
        .res (slot_res)
    );

    // ---- commit decision ----
    assign is_pq       = (cmd_reg == CMD_PLACE) || (cmd_reg == CMD_QUERY);
    assign place_ok    = (cmd_reg == CMD_PLACE) && !oor_reg && !hit_reg;
    assign do_place    = place_ok && free_found_reg;
    assign commit_fire = (state_reg == S_COMMIT) && (!out_valid_reg || !out_stall);

    // entry memory: one write in commit, one read a cycle during the sweep
    always_ff @(posedge clk)
    begin
        if (commit_fire && do_place)
            ent_mem[free_idx_reg] <= new_ent_reg;
        if (rd_en)
            rdata_reg <= ent_mem[rd_addr];
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pitch_reg      <= PITCH_RESET;
            idx_reg        <= '0;
            eval_v_reg     <= 1'b0;
            valid_reg      <= '0;
            count_reg      <= '0;
            rm_cnt_reg     <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            overlap_reg    <= 1'b0;
            placed_reg     <= 1'b0;
            oor_out_reg    <= 1'b0;
            full_reg       <= 1'b0;
            removed_reg    <= '0;
            in_use_reg     <= '0;
        end
        else
        begin
            if (cfg_wr)
                pitch_reg <= pwdata[COORD_W-1:0];

            // result register loads at commit and empties on its transfer
            if (commit_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        idx_reg        <= '0;
                        eval_v_reg     <= 1'b0;
                        rm_cnt_reg     <= '0;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    eval_v_reg <= rd_en;
                    if (rd_en)
                        idx_reg <= idx_reg + 1'b1;
                    if (eval_v_reg)
                    begin
                        if (slot_v && slot_res.hit)
                            hit_reg <= 1'b1;
                        if (!slot_v)
                            free_found_reg <= 1'b1;
                        if ((cmd_reg == CMD_REMOVE) && slot_v && slot_res.near)
                        begin
                            valid_reg[pend_idx_reg] <= 1'b0;
                            count_reg               <= count_reg - 1'b1;
                            rm_cnt_reg              <= rm_cnt_reg + 1'b1;
                        end
                    end
                    if (!rd_en && !eval_v_reg)
                        state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    if (commit_fire)
                    begin
                        if (do_place)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                            count_reg               <= count_reg + 1'b1;
                        end
                        overlap_reg <= is_pq && hit_reg;
                        placed_reg  <= do_place;
                        oor_out_reg <= is_pq && oor_reg;
                        full_reg    <= place_ok && !free_found_reg;
                        removed_reg <= (cmd_reg == CMD_REMOVE) ? COUNT_W'(rm_cnt_reg) : '0;
                        in_use_reg  <= COUNT_W'(count_reg + CNT_W'(do_place));
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg         <= cmd_t'(command);
            oor_reg         <= oor_in;
            qry_reg         <= qry_in;
            new_ent_reg.ctr <= in_pos;
            new_ent_reg.ext <= in_size;
        end
        if (rd_en)
            pend_idx_reg <= rd_addr;
        // lowest free slot: first invalid slot of the sweep
        if ((state_reg == S_SCAN) && eval_v_reg && !slot_v && !free_found_reg)
            free_idx_reg <= pend_idx_reg;
    end

    assign overlap_found  = overlap_reg;
    assign placed         = placed_reg;
    assign out_of_range   = oor_out_reg;
    assign table_full     = full_reg;
    assign removed_count  = removed_reg;
    assign entries_in_use = in_use_reg;

    // ---- assertions ----

    // stored count always tracks the valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == count_reg)
        else $error("stored count differs from number of valid slots");

    // a placed box never overlaps, is never out of range and never reports a full table
    a_place_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && placed_reg |-> !overlap_reg && !oor_out_reg && !full_reg)
        else $error("placed result with conflicting flags");

    // a new command is taken only from idle and starts the sweep
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_SCAN) && in_stall)
        else $error("accepted command did not start a sweep");

    // the entry memory is read only during the sweep
    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (state_reg == S_SCAN) && !in_stall == 1'b0)
        else $error("entry memory read outside the sweep");

    // a result is loaded only when the output register is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        commit_fire |-> !(out_valid_reg && out_stall))
        else $error("result overwrote a stalled transfer");

endmodule
